// ===== hdl/spg_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the spatial hash grid builder.
// Used by the divider, the key unit and the top level; depends on nothing.
package spg_pkg;

	localparam logic [1:0] OP_LOAD       = 2'd0;
	localparam logic [1:0] OP_READ_SLOT  = 2'd1;
	localparam logic [1:0] OP_READ_START = 2'd2;

	localparam logic [31:0] HASH_MUL_X = 32'd73856093;
	localparam logic [31:0] HASH_MUL_Y = 32'd19349663;

	// The table size is a power of two, so the key is the low bits of the hash magnitude.
	localparam int MAX_PARTICLES = 1024;
	localparam int TABLE_SIZE    = 4096;

	typedef struct packed {
		logic        start;
		logic [31:0] dividend;
		logic [31:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quotient;
		logic [31:0] remainder;
	} div_rsp_t;

endpackage

// ===== hdl/spg_div.sv =====
`timescale 1ns / 1ps
// Restoring unsigned 32-bit divider, one quotient bit per cycle.
// Depends on spg_pkg for the request and response structs.
module spg_div (
	input  logic              clk,
	input  logic              arst_n,
	input  spg_pkg::div_req_t req,
	output spg_pkg::div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] den_q;
	logic [32:0] trial;
	logic [33:0] diff;
	logic        load;

	assign load  = !busy_q && req.start;
	assign trial = {rem_q, quo_q[31]};
	assign diff  = {1'b0, trial} - {2'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (load) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			quo_q <= req.dividend;
			rem_q <= '0;
			den_q <= req.divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign rsp.done      = done_q;
	assign rsp.quotient  = quo_q;
	assign rsp.remainder = rem_q;

endmodule

// ===== hdl/spg_key.sv =====
`timescale 1ns / 1ps
// Cell key sequencer: floor division of both coordinates, hash and table modulo.
// Depends on spg_pkg and instantiates the shared divider spg_div.
module spg_key (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	input  logic [31:0]                           px,
	input  logic [31:0]                           py,
	input  logic [30:0]                           cell_size,
	output logic                                  done,
	output logic [$clog2(spg_pkg::TABLE_SIZE)-1:0] key
);

	localparam int KW = $clog2(spg_pkg::TABLE_SIZE);

	localparam logic [2:0] K_IDLE = 3'd0;
	localparam logic [2:0] K_DX   = 3'd1;
	localparam logic [2:0] K_MX   = 3'd2;
	localparam logic [2:0] K_DY   = 3'd3;
	localparam logic [2:0] K_MY   = 3'd4;
	localparam logic [2:0] K_MG   = 3'd5;

	logic [2:0]        state_q;
	logic              done_q;
	logic [31:0]       py_q;
	logic [31:0]       d_q;
	logic              neg_q;
	logic [31:0]       coord_q;
	logic [31:0]       hx_q;
	logic [31:0]       hy_q;
	logic [KW-1:0]     key_q;
	logic [31:0]       d_now;
	logic [31:0]       abs_px;
	logic [31:0]       abs_py;
	logic [31:0]       hash;
	logic [31:0]       mag;
	logic [31:0]       coord;
	logic [31:0]       mul_c;
	logic [31:0]       prod;
	spg_pkg::div_req_t div_req;
	spg_pkg::div_rsp_t div_rsp;

	spg_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign d_now  = (cell_size == 31'd0) ? 32'd1 : {1'b0, cell_size};
	assign abs_px = px[31] ? (~px + 32'd1) : px;
	assign abs_py = py_q[31] ? (~py_q + 32'd1) : py_q;
	assign hash   = hx_q ^ hy_q;
	assign mag    = hash[31] ? (~hash + 32'd1) : hash;
	assign coord  = neg_q ? (~div_rsp.quotient + {31'd0, div_rsp.remainder == 32'd0})
	                      : div_rsp.quotient;
	assign mul_c  = (state_q == K_MX) ? spg_pkg::HASH_MUL_X : spg_pkg::HASH_MUL_Y;
	assign prod   = coord_q * mul_c;

	always_comb begin
		div_req.start    = 1'b0;
		div_req.dividend = abs_px;
		div_req.divisor  = d_now;
		case (state_q)
			K_IDLE: begin
				div_req.start = start;
			end
			K_MX: begin
				div_req.start    = 1'b1;
				div_req.dividend = abs_py;
				div_req.divisor  = d_q;
			end
			default: begin
				div_req.start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= K_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				K_IDLE: if (start) state_q <= K_DX;
				K_DX:   if (div_rsp.done) state_q <= K_MX;
				K_MX:   state_q <= K_DY;
				K_DY:   if (div_rsp.done) state_q <= K_MY;
				K_MY:   state_q <= K_MG;
				K_MG: begin
					state_q <= K_IDLE;
					done_q  <= 1'b1;
				end
				default: state_q <= K_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			K_IDLE: begin
				if (start) begin
					py_q  <= py;
					d_q   <= d_now;
					neg_q <= px[31];
				end
			end
			K_DX: if (div_rsp.done) coord_q <= coord;
			K_MX: begin
				hx_q  <= prod;
				neg_q <= py_q[31];
			end
			K_DY: if (div_rsp.done) coord_q <= coord;
			K_MY: hy_q <= prod;
			K_MG: key_q <= mag[KW-1:0];
			default: begin
			end
		endcase
	end

	assign done = done_q;
	assign key  = key_q;

endmodule

// ===== hdl/spatial_hash_grid_build.sv =====
`timescale 1ns / 1ps
// Top level of the spatial hash grid builder: position, sorted and table memories
// and the build sequencer. Depends on spg_pkg and instantiates spg_key.
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   operation pos_x pos_y last_particle slot cell_query
//   out      output     out_valid / out_stall particle_index cell_key start_slot cell_empty invalid
//   cfg      input      cfg_wr_en             cfg_wr_data (cell_size)
//
// A load is stored when it is accepted; a read goes through the read state, which registers its result word.
// A load marked last runs a build: a sweep clearing the tables, a key for each particle
// (two divisions each), a prefix sweep over the table, a scatter of each particle into
// sorted order and a closing step.
// Reset leaves the start table reading as empty until the first build.
// Input is stalled while a build or read runs and while a result word is stalled.
module spatial_hash_grid_build (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [31:0] pos_x,
	input  logic [31:0] pos_y,
	input  logic        last_particle,
	input  logic [9:0]  slot,
	input  logic [11:0] cell_query,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [9:0]  particle_index,
	output logic [11:0] cell_key,
	output logic [9:0]  start_slot,
	output logic        cell_empty,
	output logic        invalid,
	input  logic        cfg_wr_en,
	input  logic [30:0] cfg_wr_data
);

	localparam int MAX_PARTICLES = spg_pkg::MAX_PARTICLES;
	localparam int TABLE_SIZE    = spg_pkg::TABLE_SIZE;
	localparam int PW = $clog2(MAX_PARTICLES);
	localparam int CW = $clog2(MAX_PARTICLES + 1);
	localparam int KW = $clog2(TABLE_SIZE);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RD   = 4'd1;
	localparam logic [3:0] S_CLR  = 4'd2;
	localparam logic [3:0] S_KRD  = 4'd3;
	localparam logic [3:0] S_KGO  = 4'd4;
	localparam logic [3:0] S_KWT  = 4'd5;
	localparam logic [3:0] S_KINC = 4'd6;
	localparam logic [3:0] S_PRD  = 4'd7;
	localparam logic [3:0] S_PUP  = 4'd8;
	localparam logic [3:0] S_SRD  = 4'd9;
	localparam logic [3:0] S_SK   = 4'd10;
	localparam logic [3:0] S_SW   = 4'd11;
	localparam logic [3:0] S_FIN  = 4'd12;

	logic [3:0]    state_q;
	logic [30:0]   cell_size_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] sorted_count_q;
	logic          closed_q;
	logic          built_q;
	logic [CW-1:0] i_q;
	logic [KW-1:0] k_q;
	logic [CW-1:0] run_q;
	logic [KW-1:0] key_hold_q;
	logic [1:0]    op_q;
	logic [9:0]    slot_q;
	logic [11:0]   query_q;
	logic          out_valid_q;

	logic [9:0]    pidx_q;
	logic [11:0]   ckey_q;
	logic [9:0]    sslot_q;
	logic          empty_q;
	logic          inval_q;

	logic [31:0]   px_mem [MAX_PARTICLES];
	logic [31:0]   py_mem [MAX_PARTICLES];
	logic [KW-1:0] ks_mem [MAX_PARTICLES];
	logic [PW-1:0] sidx_mem [MAX_PARTICLES];
	logic [KW-1:0] skey_mem [MAX_PARTICLES];
	logic [CW-1:0] cnt_mem [TABLE_SIZE];
	logic [PW:0]   st_mem [TABLE_SIZE];

	logic [31:0]   px_rd;
	logic [31:0]   py_rd;
	logic [KW-1:0] ks_rd;
	logic [PW-1:0] sidx_rd;
	logic [KW-1:0] skey_rd;
	logic [CW-1:0] cnt_rd;
	logic [PW:0]   st_rd;

	logic          accept;
	logic          is_load;
	logic [CW-1:0] base;
	logic          store_ok;
	logic          key_start;
	logic          key_done;
	logic [KW-1:0] key_val;
	logic [KW-1:0] cnt_raddr;
	logic          cnt_we;
	logic [KW-1:0] cnt_waddr;
	logic [CW-1:0] cnt_wdata;
	logic          st_we;
	logic [PW:0]   st_wdata;
	logic [31:0]   slot_ext;
	logic [31:0]   query_ext;
	logic          last_i;

	assign in_stall  = !((state_q == S_IDLE) && (!out_valid_q || !out_stall));
	assign accept    = in_valid && !in_stall;
	assign is_load   = accept && (operation == spg_pkg::OP_LOAD);
	assign base      = closed_q ? '0 : count_q;
	assign store_ok  = base < CW'(MAX_PARTICLES);
	assign key_start = (state_q == S_KGO);
	assign slot_ext  = {22'd0, slot};
	assign query_ext = {20'd0, cell_query};
	assign last_i    = (i_q == count_q - CW'(1));

	spg_key u_key (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (key_start),
		.px        (px_rd),
		.py        (py_rd),
		.cell_size (cell_size_q),
		.done      (key_done),
		.key       (key_val)
	);

	always_comb begin
		cnt_raddr = k_q;
		cnt_we    = 1'b0;
		cnt_waddr = k_q;
		cnt_wdata = '0;
		st_we     = 1'b0;
		st_wdata  = '0;
		case (state_q)
			S_CLR: begin
				cnt_we = 1'b1;
				st_we  = 1'b1;
			end
			S_KWT: cnt_raddr = key_val;
			S_KINC: begin
				cnt_we    = 1'b1;
				cnt_waddr = key_hold_q;
				cnt_wdata = cnt_rd + CW'(1);
			end
			S_PUP: begin
				cnt_we    = 1'b1;
				cnt_wdata = run_q;
				st_we     = (cnt_rd != '0);
				st_wdata  = {1'b1, run_q[PW-1:0]};
			end
			S_SK: cnt_raddr = ks_rd;
			S_SW: begin
				cnt_we    = 1'b1;
				cnt_waddr = key_hold_q;
				cnt_wdata = cnt_rd + CW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (is_load && store_ok) begin
			px_mem[base[PW-1:0]] <= pos_x;
			py_mem[base[PW-1:0]] <= pos_y;
		end
		px_rd <= px_mem[i_q[PW-1:0]];
		py_rd <= py_mem[i_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_KINC) ks_mem[i_q[PW-1:0]] <= key_hold_q;
		ks_rd <= ks_mem[i_q[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (state_q == S_SW) begin
			sidx_mem[cnt_rd[PW-1:0]] <= i_q[PW-1:0];
			skey_mem[cnt_rd[PW-1:0]] <= key_hold_q;
		end
		sidx_rd <= sidx_mem[slot_ext[PW-1:0]];
		skey_rd <= skey_mem[slot_ext[PW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
		cnt_rd <= cnt_mem[cnt_raddr];
	end

	always_ff @(posedge clk) begin
		if (st_we) st_mem[k_q] <= st_wdata;
		st_rd <= st_mem[query_ext[KW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			cell_size_q    <= 31'd65536;
			count_q        <= '0;
			sorted_count_q <= '0;
			closed_q       <= 1'b0;
			built_q        <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (cfg_wr_en) cell_size_q <= cfg_wr_data;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (operation)
							spg_pkg::OP_LOAD: begin
								closed_q <= 1'b0;
								count_q  <= base + CW'(store_ok);
								if (last_particle) state_q <= S_CLR;
							end
							spg_pkg::OP_READ_SLOT:  state_q <= S_RD;
							spg_pkg::OP_READ_START: state_q <= S_RD;
							default:                state_q <= S_IDLE;
						endcase
					end
				end
				S_RD: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				S_CLR: begin
					if (k_q == KW'(TABLE_SIZE - 1)) begin
						state_q <= (count_q == '0) ? S_FIN : S_KRD;
					end
				end
				S_KRD: state_q <= S_KGO;
				S_KGO: state_q <= S_KWT;
				S_KWT: if (key_done) state_q <= S_KINC;
				S_KINC: state_q <= last_i ? S_PRD : S_KRD;
				S_PRD: state_q <= S_PUP;
				S_PUP: state_q <= (k_q == KW'(TABLE_SIZE - 1)) ? S_SRD : S_PRD;
				S_SRD: state_q <= S_SK;
				S_SK:  state_q <= S_SW;
				S_SW:  state_q <= last_i ? S_FIN : S_SRD;
				S_FIN: begin
					sorted_count_q <= count_q;
					closed_q       <= 1'b1;
					built_q        <= 1'b1;
					state_q        <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				k_q     <= '0;
				i_q     <= '0;
				op_q    <= operation;
				slot_q  <= slot;
				query_q <= cell_query;
			end
			S_RD: begin
				pidx_q  <= '0;
				ckey_q  <= '0;
				sslot_q <= '0;
				empty_q <= 1'b0;
				inval_q <= 1'b0;
				if (op_q == spg_pkg::OP_READ_SLOT) begin
					if ({22'd0, slot_q} < 32'(sorted_count_q)) begin
						pidx_q <= 10'(sidx_rd);
						ckey_q <= 12'(skey_rd);
					end else begin
						inval_q <= 1'b1;
					end
				end else begin
					if (built_q && ({20'd0, query_q} < 32'(TABLE_SIZE)) && st_rd[PW]) begin
						sslot_q <= 10'(st_rd[PW-1:0]);
					end else begin
						empty_q <= 1'b1;
					end
				end
			end
			S_CLR: begin
				k_q   <= (k_q == KW'(TABLE_SIZE - 1)) ? '0 : k_q + KW'(1);
				run_q <= '0;
			end
			S_KWT: if (key_done) key_hold_q <= key_val;
			S_KINC: i_q <= last_i ? '0 : i_q + CW'(1);
			S_PUP: begin
				run_q <= run_q + cnt_rd;
				k_q   <= k_q + KW'(1);
			end
			S_SK: key_hold_q <= ks_rd;
			S_SW: i_q <= i_q + CW'(1);
			default: begin
			end
		endcase
	end

	assign out_valid      = out_valid_q;
	assign particle_index = pidx_q;
	assign cell_key       = ckey_q;
	assign start_slot     = sslot_q;
	assign cell_empty     = empty_q;
	assign invalid        = inval_q;

	a_key_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		key_done |-> (state_q == S_KWT))
		else $error("key unit finished outside the key wait state");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(MAX_PARTICLES))
		else $error("particle count exceeds the store depth");

	a_out_from_read: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_RD))
		else $error("result word raised without a read");

	a_sorted_follows_build: assert property (@(posedge clk) disable iff (!arst_n)
		(sorted_count_q != $past(sorted_count_q)) |-> ($past(state_q) == S_FIN))
		else $error("sorted count changed outside a build");

endmodule
